// ----- sv/adpcm4_pkg.sv -----
// Shared constants for the 4-bit ADPCM decoder: step size table, index
// adaptation table and sample limits.
// No dependencies.
package adpcm4_pkg;

  localparam int TableLast   = 88;
  localparam int StepW       = 15;
  localparam int TableIdxW   = 7;
  localparam int SampleW     = 12;
  localparam int SampleLimit = 2047;

  typedef logic [StepW-1:0]   step_t;
  typedef logic [SampleW-1:0] sample_t;

  localparam step_t STEP_SIZES [0:TableLast] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
    15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
    15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
    15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
    15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
    15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2047,  15'd2272,  15'd2499,  15'd2749,
    15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
    15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
    15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

  localparam logic signed [4:0] INDEX_MOVES [0:7] = '{
    -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
  };

  function automatic step_t step_of(input logic [TableIdxW-1:0] idx);
    return STEP_SIZES[idx];
  endfunction

endpackage

// ----- sv/adpcm_4bit_decoder.sv -----
// 4-bit ADPCM decoder: one byte in, two 12-bit offset-binary samples out.
// Each byte is held in byte_r; its low nibble is decoded into the registered
// output first, then its high nibble, and the next byte can be taken as the high
// nibble is decoded. One nibble is decoded per cycle while the output is not
// stalled, through the step lookup, scaled delta add and saturation.
// Reset (synchronous, active low) clears the step index, the running sample
// and all valid flags.
module adpcm_4bit_decoder #(
  parameter int MAX_STEP_INDEX = 59
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] code_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [11:0] pcm_sample, [15:12] zero
  output logic        out_tlast   // last_of_pair
);
  import adpcm4_pkg::*;

  localparam int Top = (MAX_STEP_INDEX > TableLast) ? TableLast : MAX_STEP_INDEX;
  localparam int IdxW = (Top < 1) ? 1 : $clog2(Top + 1);
  localparam int SumIdxW = IdxW + 5;

  logic [7:0]           byte_r;
  logic                 full_r;
  logic                 phase_r;
  logic [IdxW-1:0]      step_index_r;
  logic signed [11:0]   predicted_r;
  logic                 out_valid_r;
  sample_t              out_pcm_r;
  logic                 out_last_r;

  logic                 advance;
  logic                 in_acc;
  logic [3:0]           nib;
  logic [2:0]           mag;
  step_t                step;
  logic [17:0]          prod;
  logic [16:0]          delta;
  logic signed [17:0]   sum;
  logic signed [11:0]   predicted_nxt;
  logic signed [SumIdxW-1:0] idx_sum;
  logic [IdxW-1:0]      step_index_nxt;

  assign advance   = full_r && (!out_valid_r || out_tready);
  assign in_tready = !full_r || (phase_r && advance);
  assign in_acc    = in_tvalid && in_tready;

  assign nib   = phase_r ? byte_r[7:4] : byte_r[3:0];
  assign mag   = nib[2:0];
  assign step  = step_of(TableIdxW'(step_index_r));
  assign prod  = 18'(step) * 18'(mag);
  assign delta = 17'(prod[17:2]) + 17'(step[StepW-1:3]);

  always_comb begin
    if (nib[3]) begin
      sum = 18'(predicted_r) - signed'({1'b0, delta});
    end else begin
      sum = 18'(predicted_r) + signed'({1'b0, delta});
    end
    if (sum > 18'sd2047) begin
      predicted_nxt = 12'(SampleLimit);
    end else if (sum < -18'sd2047) begin
      predicted_nxt = -12'(SampleLimit);
    end else begin
      predicted_nxt = sum[11:0];
    end

    idx_sum = signed'(SumIdxW'(step_index_r)) + SumIdxW'(INDEX_MOVES[mag]);
    if (idx_sum < 0) begin
      step_index_nxt = '0;
    end else if (idx_sum > SumIdxW'(Top)) begin
      step_index_nxt = IdxW'(Top);
    end else begin
      step_index_nxt = idx_sum[IdxW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r       <= 1'b0;
      phase_r      <= 1'b0;
      step_index_r <= '0;
      predicted_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        step_index_r <= step_index_nxt;
        predicted_r  <= predicted_nxt;
        out_valid_r  <= 1'b1;
        out_pcm_r    <= sample_t'(predicted_nxt) + sample_t'(SampleLimit);
        out_last_r   <= phase_r;
        phase_r      <= !phase_r;
        if (phase_r) begin
          full_r <= 1'b0;
        end
      end
      if (in_acc) begin
        byte_r  <= in_tdata;
        full_r  <= 1'b1;
        phase_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_pcm_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- bench/tb_adpcm_4bit_decoder.sv -----
// Self-checking bench for adpcm_4bit_decoder: directed code bytes, then random
// bytes under several sender and receiver idling patterns, checked per sample.
// Depends on adpcm4_pkg for the step and index tables and the sample type.
module tb_adpcm_4bit_decoder;
  import adpcm4_pkg::*;

  localparam int MaxIdx      = 59;
  localparam int TopIdx      = (MaxIdx > TableLast) ? TableLast : MaxIdx;
  localparam int RandWords   = 250;
  localparam int HoldCycles  = 200;
  localparam int DrainCycles = 10;
  localparam int CycleLimit  = 300000;

  typedef struct packed {
    logic [7:0] code;
    logic       typed;
    sample_t    first;
    sample_t    second;
  } code_row_t;

  typedef struct packed {
    sample_t pcm;
    logic    last;
  } pcm_exp_t;

  localparam int DirRows = 24;
  localparam code_row_t DIRECTED [0:DirRows-1] = '{
    '{8'h00, 1'b1, 12'd2047, 12'd2047},
    '{8'h88, 1'b1, 12'd2047, 12'd2047},
    '{8'h01, 1'b1, 12'd2048, 12'd2048},
    '{8'h09, 1'b1, 12'd2047, 12'd2047},
    '{8'h77, 1'b0, 12'd0, 12'd0},
    '{8'h77, 1'b0, 12'd0, 12'd0},
    '{8'h77, 1'b0, 12'd0, 12'd0},
    '{8'h77, 1'b0, 12'd0, 12'd0},
    '{8'h77, 1'b0, 12'd0, 12'd0},
    '{8'h77, 1'b1, 12'd4094, 12'd4094},
    '{8'hff, 1'b1, 12'd257, 12'd0},
    '{8'hff, 1'b1, 12'd0, 12'd0},
    '{8'hff, 1'b0, 12'd0, 12'd0},
    '{8'hff, 1'b0, 12'd0, 12'd0},
    '{8'hff, 1'b0, 12'd0, 12'd0},
    '{8'hff, 1'b0, 12'd0, 12'd0},
    '{8'h10, 1'b0, 12'd0, 12'd0},
    '{8'h32, 1'b0, 12'd0, 12'd0},
    '{8'h54, 1'b0, 12'd0, 12'd0},
    '{8'h76, 1'b0, 12'd0, 12'd0},
    '{8'h98, 1'b0, 12'd0, 12'd0},
    '{8'hba, 1'b0, 12'd0, 12'd0},
    '{8'hdc, 1'b0, 12'd0, 12'd0},
    '{8'hfe, 1'b0, 12'd0, 12'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] code_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [11:0] pcm_sample, [15:12] zero
  logic        out_tlast;          // last_of_pair

  int       step_pos = 0;
  int       run_val = 0;
  pcm_exp_t pcm_due[$];
  int       mismatch_cnt = 0;
  int       cycle_cnt = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  bit       hold_req = 1'b0;

  adpcm_4bit_decoder #(.MAX_STEP_INDEX(MaxIdx)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatch_cnt++;
  endtask

  // Decodes one nibble and advances the running sample and step index.
  function automatic sample_t decode_code(input logic [3:0] code);
    int unsigned step;
    int unsigned mag;
    int          delta;
    step  = STEP_SIZES[step_pos];
    mag   = code[2:0];
    delta = int'((step * mag) / 4 + step / 8);
    if (code[3]) begin
      delta = -delta;
    end
    run_val = run_val + delta;
    if (run_val > SampleLimit) begin
      run_val = SampleLimit;
    end else if (run_val < -SampleLimit) begin
      run_val = -SampleLimit;
    end
    step_pos = step_pos + int'(INDEX_MOVES[mag]);
    if (step_pos < 0) begin
      step_pos = 0;
    end else if (step_pos > TopIdx) begin
      step_pos = TopIdx;
    end
    return sample_t'(run_val + SampleLimit);
  endfunction

  function automatic logic [7:0] random_code();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        b[6] = 1'b1;
        b[2] = 1'b1;
      end
      3, 4: begin
        b[6] = 1'b0;
        b[2] = 1'b0;
      end
      default: begin
      end
    endcase
    return b;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [7:0] b, input logic typed,
                           input sample_t want0, input sample_t want1);
    sample_t first;
    sample_t second;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    first  = decode_code(b[3:0]);
    second = decode_code(b[7:4]);
    if (typed) begin
      first  = want0;
      second = want1;
    end
    pcm_due.push_back('{pcm: first, last: 1'b0});
    pcm_due.push_back('{pcm: second, last: 1'b1});
    @(negedge clk);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    pcm_exp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pcm_due.size() == 0) begin
        report_mismatch("unexpected sample", int'(out_tdata), -1);
      end else begin
        want = pcm_due.pop_front();
        if (out_tdata[11:0] !== want.pcm) begin
          report_mismatch("pcm_sample", int'(out_tdata[11:0]), int'(want.pcm));
        end
        if (out_tdata[15:12] !== 4'h0) begin
          report_mismatch("tdata padding", int'(out_tdata[15:12]), 0);
        end
        if (out_tlast !== want.last) begin
          report_mismatch("last_of_pair", int'(out_tlast), int'(want.last));
        end
      end
    end
  end

  initial begin
    int send_plan [0:4];
    int stall_plan [0:4];
    send_plan  = '{0, 71, 0, 38, 0};
    stall_plan = '{0, 0, 71, 38, 0};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < DirRows; r++) begin
      send_word(DIRECTED[r].code, DIRECTED[r].typed, DIRECTED[r].first,
                DIRECTED[r].second);
    end

    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct = send_plan[ph];
      stall_pct     = stall_plan[ph];
      // The last phase holds the output off for a long stretch so that the
      // decoder fills up and pushes back on its input.
      if (ph == 4) begin
        hold_req = 1'b1;
      end
      for (int i = 0; i < RandWords; i++) begin
        send_word(random_code(), 1'b0, 12'd0, 12'd0);
      end
    end
    in_tvalid <= 1'b0;

    while (pcm_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (pcm_due.size() != 0) begin
      report_mismatch("missing samples", 0, pcm_due.size());
    end
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
